// ===== rtl/tccw_pkg.sv =====
// shared constants, types and helpers for the text console character writer
// no dependencies
`default_nettype none

package tccw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int CELL_W  = 16;

    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0F20;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int TAB_STEP = 8;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef enum logic [0:0] {
        REG_FG = 1'b0,
        REG_BG = 1'b1
    } t_reg;

    typedef struct packed {
        logic [3:0] fg;
        logic [3:0] bg;
    } t_colours;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    // linear cell offset of a row and column
    function automatic logic [31:0] cell_index(input logic [7:0] row, input logic [7:0] col);
        cell_index = 32'(row) * 32'(COLUMNS) + 32'(col);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tccw_ram.sv =====
// generic simple dual port ram, one write port, one registered read port
// no dependencies
`default_nettype none

module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/tccw_regs.sv =====
// colour registers behind the apb-style configuration port
// depends on tccw_pkg
`default_nettype none

module tccw_regs
    import tccw_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        i_reg_sel,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output t_colours         o_colours
);

    logic [3:0] r_fg, n_fg;
    logic [3:0] r_bg, n_bg;

    always_comb begin
        n_fg = r_fg;
        n_bg = r_bg;
        if (psel && penable && pwrite) begin
            case (t_reg'(i_reg_sel))
                REG_FG:  n_fg = pwdata[3:0];
                REG_BG:  n_bg = pwdata[3:0];
                default: n_fg = r_fg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= 4'hF;
            r_bg <= 4'h0;
        end else begin
            r_fg <= n_fg;
            r_bg <= n_bg;
        end
    end

    assign prdata    = (t_reg'(i_reg_sel) == REG_BG) ? {28'd0, r_bg} : {28'd0, r_fg};
    assign o_colours = '{fg: r_fg, bg: r_bg};

endmodule

`default_nettype wire

// ===== rtl/tccw_ctrl.sv =====
// command sequencer: cursor, writes and reads of the screen ram, scroll copy,
// blank fill and the output register; depends on tccw_pkg
`default_nettype none

module tccw_ctrl
    import tccw_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_colours          i_colours,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_cmd,
    input  wire logic [7:0]        i_char_code,
    input  wire logic [4:0]        i_read_row,
    input  wire logic [6:0]        i_read_column,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic      [10:0]       o_cursor_index,
    output logic      [15:0]       o_cell_data,
    output logic                   o_scrolled,
    output t_mem_req               o_mem,
    input  wire logic [CELL_W-1:0] i_rdata
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_MOVE = 5'b00100,
        ST_FILL = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              r_init, n_init;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic              r_rd_ok, n_rd_ok;
    logic [15:0]       r_res_data, n_res_data;
    logic              r_res_scr, n_res_scr;
    logic              r_o_valid, n_o_valid;
    logic [10:0]       r_o_cursor, n_o_cursor;
    logic [15:0]       r_o_data, n_o_data;
    logic              r_o_scr, n_o_scr;

    logic [CELL_W-1:0] blank;
    logic              accept;
    logic              load_out;

    assign blank      = {i_colours.bg, i_colours.fg, CH_SPACE};
    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign load_out   = (r_state == ST_DONE) && (!r_o_valid || !i_out_stall);

    always_comb begin
        logic [COL_W:0] nc;
        logic [ROW_W:0] nr;
        logic [31:0]    idx;

        n_state    = r_state;
        n_addr     = r_addr;
        n_init     = r_init;
        n_col      = r_col;
        n_row      = r_row;
        n_rd_ok    = r_rd_ok;
        n_res_data = r_res_data;
        n_res_scr  = r_res_scr;
        nc         = {1'b0, r_col};
        nr         = {1'b0, r_row};
        idx        = cell_index(8'(r_row), 8'(r_col));
        o_mem      = '{we: 1'b0, waddr: r_addr, wdata: blank, raddr: '0};

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_res_data = '0;
                    n_res_scr  = 1'b0;
                    case (t_cmd'(i_cmd))
                        CMD_PUT: begin
                            if (i_char_code == CH_BS) begin
                                if (r_col != '0) begin
                                    nc = nc - 1'b1;
                                end
                            end else if (i_char_code == CH_TAB) begin
                                nc = (nc + (COL_W+1)'(TAB_STEP)) & ~(COL_W+1)'(TAB_STEP - 1);
                            end else if (i_char_code == CH_CR) begin
                                nc = '0;
                            end else if (i_char_code == CH_LF) begin
                                nc = '0;
                                nr = nr + 1'b1;
                            end else if (i_char_code >= CH_SPACE) begin
                                o_mem.we    = 1'b1;
                                o_mem.waddr = idx[ADDR_W-1:0];
                                o_mem.wdata = {i_colours.bg, i_colours.fg, i_char_code};
                                nc = nc + 1'b1;
                            end
                            if (nc >= (COL_W+1)'(COLUMNS)) begin
                                nc = '0;
                                nr = nr + 1'b1;
                            end
                            n_col = nc[COL_W-1:0];
                            if (nr >= (ROW_W+1)'(ROWS)) begin
                                n_row     = ROW_W'(ROWS - 1);
                                n_res_scr = 1'b1;
                                n_addr    = '0;
                                n_state   = ST_MOVE;
                            end else begin
                                n_row   = nr[ROW_W-1:0];
                                n_state = ST_DONE;
                            end
                        end
                        CMD_CLEAR: begin
                            n_col   = '0;
                            n_row   = '0;
                            n_addr  = '0;
                            n_state = ST_FILL;
                        end
                        CMD_READ: begin
                            n_rd_ok = ({3'd0, i_read_row} < 8'(ROWS))
                                   && ({1'b0, i_read_column} < 8'(COLUMNS));
                            idx = cell_index({3'd0, i_read_row}, {1'b0, i_read_column});
                            if (n_rd_ok) begin
                                o_mem.raddr = idx[ADDR_W-1:0];
                            end
                            n_state = ST_READ;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_res_data = r_rd_ok ? i_rdata : '0;
                n_state    = ST_DONE;
            end
            ST_MOVE: begin
                // read one row ahead, write back what came out of the last read
                if (r_addr < ADDR_W'(CELLS - COLUMNS)) begin
                    o_mem.raddr = r_addr + ADDR_W'(COLUMNS);
                end
                if (r_addr != '0) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_addr - 1'b1;
                    o_mem.wdata = i_rdata;
                end
                if (r_addr == ADDR_W'(CELLS - COLUMNS)) begin
                    n_state = ST_FILL;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_FILL: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_addr;
                o_mem.wdata = r_init ? RESET_CELL : blank;
                if (r_addr == ADDR_W'(CELLS - 1)) begin
                    n_init  = 1'b0;
                    n_state = r_init ? ST_IDLE : ST_DONE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        logic [31:0] cur;
        cur        = cell_index(8'(r_row), 8'(r_col));
        n_o_valid  = r_o_valid && i_out_stall;
        n_o_cursor = r_o_cursor;
        n_o_data   = r_o_data;
        n_o_scr    = r_o_scr;
        if (load_out) begin
            n_o_valid  = 1'b1;
            n_o_cursor = cur[10:0];
            n_o_data   = r_res_data;
            n_o_scr    = r_res_scr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_FILL;
            r_addr    <= '0;
            r_init    <= 1'b1;
            r_col     <= '0;
            r_row     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_init    <= n_init;
            r_col     <= n_col;
            r_row     <= n_row;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ok    <= n_rd_ok;
        r_res_data <= n_res_data;
        r_res_scr  <= n_res_scr;
        r_o_cursor <= n_o_cursor;
        r_o_data   <= n_o_data;
        r_o_scr    <= n_o_scr;
    end

    assign o_out_valid    = r_o_valid;
    assign o_cursor_index = r_o_cursor;
    assign o_cell_data    = r_o_data;
    assign o_scrolled     = r_o_scr;

    // cursor stays on the screen between transactions
    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_col < COL_W'(COLUMNS)) && ({1'b0, r_row} < (ROW_W+1)'(ROWS)))
        else $error("cursor off screen");

    // no transaction is taken during the power-up clearing pass
    a_no_accept_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !accept)
        else $error("input accepted during clearing pass");

    // a finished result waits while the output register is still held
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) && r_o_valid && i_out_stall |=> (r_state == ST_DONE))
        else $error("result lost while output stalled");

    // a scroll copy always ends in the bottom row fill
    a_move_to_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MOVE) && (r_addr == ADDR_W'(CELLS - COLUMNS)) |=>
        (r_state == ST_FILL) && (r_addr == ADDR_W'(CELLS - COLUMNS)))
        else $error("scroll did not hand over to fill");

endmodule

`default_nettype wire

// ===== rtl/text_console_character_writer.sv =====
// text console character writer: screen of cells in one ram plus a cursor
// a clear blanks every cell; a scroll copies each row up by one row and blanks
// the bottom row: one ram write port, one cell per cycle
// one transaction in flight: the input stalls until its result is loaded
// reset: a clearing pass writes 0x0F20 to every cell,
// input stalled meanwhile; depends on tccw_pkg, tccw_regs, tccw_ctrl, tccw_ram
`default_nettype none

module text_console_character_writer
    import tccw_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [7:0]  i_char_code,
    input  wire logic [4:0]  i_read_row,
    input  wire logic [6:0]  i_read_column,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [10:0] o_cursor_index,
    output logic      [15:0] o_cell_data,
    output logic             o_scrolled
);

    t_colours          colours;
    t_mem_req          mem_req;
    logic [CELL_W-1:0] rdata;

    assign pready = 1'b1;

    tccw_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .i_reg_sel (paddr[2]),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .o_colours (colours)
    );

    tccw_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_colours      (colours),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_char_code    (i_char_code),
        .i_read_row     (i_read_row),
        .i_read_column  (i_read_column),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_cursor_index (o_cursor_index),
        .o_cell_data    (o_cell_data),
        .o_scrolled     (o_scrolled),
        .o_mem          (mem_req),
        .i_rdata        (rdata)
    );

    tccw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (rdata)
    );

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// self-checking testbench for text_console_character_writer: directed rows, then random
// commands and colour settings, scored against typed results or a screen and cursor predictor
// depends on tccw_pkg and the rtl of text_console_character_writer only
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tccw_pkg::*;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         IDLE_PCT     = 29;
    localparam int         ITEMS_PHASE  = 334;
    localparam int         PHASES       = 6;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         TAIL_CYCLES  = 2100;
    localparam int         STUCK_LIMIT  = 12000;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] ch;
        logic [4:0] row;
        logic [6:0] col;
    } t_console_req;

    typedef struct packed {
        logic [10:0] cursor;
        logic [15:0] data;
        logic        scrolled;
    } t_console_outcome;

    typedef struct packed {
        t_console_req     req;
        logic             typed;
        t_console_outcome want;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_cmd;
    logic [7:0]  i_char_code;
    logic [4:0]  i_read_row;
    logic [6:0]  i_read_column;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [10:0] o_cursor_index;
    logic [15:0] o_cell_data;
    logic        o_scrolled;

    // predictor state
    logic [15:0] screen_model [CELLS];
    int          cur_col;
    int          cur_row;
    logic [3:0]  fg_now;
    logic [3:0]  bg_now;

    t_console_outcome pending_outcomes [$];
    t_stim_row        stim_rows [$];
    int               mismatches;
    logic             no_gaps;
    logic             hold_req;

    text_console_character_writer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_char_code    (i_char_code),
        .i_read_row     (i_read_row),
        .i_read_column  (i_read_column),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_cursor_index (o_cursor_index),
        .o_cell_data    (o_cell_data),
        .o_scrolled     (o_scrolled)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic void fill_blank(input int first, input int count);
        for (int i = first; i < first + count; i++) begin
            screen_model[i] = {bg_now, fg_now, CH_SPACE};
        end
    endfunction

    // advance the screen and cursor by one command, return what the block should report
    function automatic t_console_outcome step_console(input t_console_req req);
        t_console_outcome res;
        res = '0;
        case (req.cmd)
            CMD_PUT: begin
                if (req.ch == CH_BS) begin
                    if (cur_col != 0) cur_col--;
                end else if (req.ch == CH_TAB) begin
                    cur_col = (cur_col + TAB_STEP) & ~(TAB_STEP - 1);
                end else if (req.ch == CH_CR) begin
                    cur_col = 0;
                end else if (req.ch == CH_LF) begin
                    cur_col = 0;
                    cur_row++;
                end else if (req.ch >= CH_SPACE) begin
                    screen_model[cur_row * COLUMNS + cur_col] = {bg_now, fg_now, req.ch};
                    cur_col++;
                end
                if (cur_col >= COLUMNS) begin
                    cur_col = 0;
                    cur_row++;
                end
                if (cur_row >= ROWS) begin
                    for (int i = 0; i < CELLS - COLUMNS; i++) begin
                        screen_model[i] = screen_model[i + COLUMNS];
                    end
                    fill_blank(CELLS - COLUMNS, COLUMNS);
                    cur_row = ROWS - 1;
                    res.scrolled = 1'b1;
                end
            end
            CMD_CLEAR: begin
                fill_blank(0, CELLS);
                cur_col = 0;
                cur_row = 0;
            end
            CMD_READ: begin
                if (req.row < ROWS && req.col < COLUMNS) begin
                    res.data = screen_model[req.row * COLUMNS + req.col];
                end
            end
            default: ;
        endcase
        res.cursor = 11'(cur_row * COLUMNS + cur_col);
        return res;
    endfunction

    function automatic t_console_req random_console_req();
        t_console_req req;
        int pick;
        int kind;
        req.ch  = 8'($urandom_range(0, 255));
        req.row = 5'($urandom_range(0, 31));
        req.col = 7'($urandom_range(0, 127));
        pick = $urandom_range(0, 99);
        if (pick < 78) begin
            req.cmd = CMD_PUT;
            kind = $urandom_range(0, 99);
            if (kind < 70)      req.ch = 8'($urandom_range(32, 255));
            else if (kind < 77) req.ch = CH_LF;
            else if (kind < 82) req.ch = CH_TAB;
            else if (kind < 86) req.ch = CH_CR;
            else if (kind < 90) req.ch = CH_BS;
            else                req.ch = 8'($urandom_range(0, 31));
        end else if (pick < 94) begin
            req.cmd = CMD_READ;
            // mostly on screen, now and then anywhere the fields reach
            if ($urandom_range(0, 7) != 0) begin
                req.row = 5'($urandom_range(0, ROWS - 1));
                req.col = 7'($urandom_range(0, COLUMNS - 1));
            end
        end else if (pick < 95) begin
            req.cmd = CMD_CLEAR;
        end else begin
            req.cmd = CMD_UNUSED;
        end
        return req;
    endfunction

    task automatic add_row(input logic [1:0] cmd, input logic [7:0] ch, input logic [4:0] row,
                           input logic [6:0] col, input logic typed,
                           input logic [10:0] cursor, input logic [15:0] data);
        t_stim_row r;
        r.req   = '{cmd: cmd, ch: ch, row: row, col: col};
        r.typed = typed;
        r.want  = '{cursor: cursor, data: data, scrolled: 1'b0};
        stim_rows.push_back(r);
    endtask

    // starts and ends at a falling edge
    task automatic send_item(input t_console_req req, input logic typed,
                             input t_console_outcome want);
        t_console_outcome predicted;
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_cmd         = req.cmd;
        i_char_code   = req.ch;
        i_read_row    = req.row;
        i_read_column = req.col;
        do @(posedge i_clk); while (o_in_stall);
        predicted = step_console(req);
        pending_outcomes.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic drain_outcomes();
        i_in_valid = 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // apb write then read back, starts and ends at a falling edge
    task automatic write_colour(input t_reg which, input logic [3:0] value);
        logic [2:0]  addr;
        logic [31:0] got;
        addr    = {which, 2'b00};
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = addr;
        pwdata  = 32'(value);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        if (which == REG_FG) fg_now = value;
        else                 bg_now = value;
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (got != 32'(value)) flag_mismatch("colour register readback", got, value);
    endtask

    // result side: stall at random, or for a long stretch when asked
    initial begin
        int hold_left;
        t_console_outcome want;
        hold_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                if (pending_outcomes.size() == 0) begin
                    flag_mismatch("result with nothing pending", o_cursor_index, 0);
                end else begin
                    want = pending_outcomes.pop_front();
                    if (o_cursor_index !== want.cursor)
                        flag_mismatch("cursor_index", o_cursor_index, want.cursor);
                    if (o_cell_data !== want.data)
                        flag_mismatch("cell_data", o_cell_data, want.data);
                    if (o_scrolled !== want.scrolled)
                        flag_mismatch("scrolled", o_scrolled, want.scrolled);
                end
            end
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall = 1'b1;
            end else if (hold_req) begin
                hold_req    = 1'b0;
                hold_left   = HOLD_CYCLES;
                i_out_stall = 1'b1;
            end else begin
                i_out_stall = !no_gaps && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // ends the run if no transaction moves on either side for too long
    initial begin
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall))
                stuck = 0;
            else
                stuck++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        logic [3:0] fg_set;
        logic [3:0] bg_set;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_in_valid    = 1'b0;
        i_cmd         = CMD_PUT;
        i_char_code   = '0;
        i_read_row    = '0;
        i_read_column = '0;
        mismatches    = 0;
        no_gaps       = 1'b0;
        hold_req      = 1'b0;
        cur_col       = 0;
        cur_row       = 0;
        fg_now        = 4'hF;
        bg_now        = 4'h0;
        for (int i = 0; i < CELLS; i++) screen_model[i] = RESET_CELL;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // cmd, char, row, col, typed, cursor, cell data
        add_row(CMD_READ,   8'h00,  5'd0,  7'd0,   1'b1, 11'd0,  16'h0F20);
        add_row(CMD_READ,   8'hFF,  5'd31, 7'd127, 1'b1, 11'd0,  16'h0000);
        add_row(CMD_READ,   8'h00,  5'd24, 7'd79,  1'b1, 11'd0,  16'h0F20);
        add_row(CMD_READ,   8'h00,  5'd25, 7'd0,   1'b1, 11'd0,  16'h0000);
        add_row(CMD_READ,   8'h00,  5'd0,  7'd80,  1'b1, 11'd0,  16'h0000);
        add_row(CMD_UNUSED, 8'hFF,  5'd31, 7'd127, 1'b1, 11'd0,  16'h0000);
        add_row(CMD_PUT,    CH_BS,  5'd0,  7'd0,   1'b1, 11'd0,  16'h0000);
        add_row(CMD_PUT,    8'h41,  5'd0,  7'd0,   1'b1, 11'd1,  16'h0000);
        add_row(CMD_PUT,    CH_TAB, 5'd0,  7'd0,   1'b1, 11'd8,  16'h0000);
        add_row(CMD_PUT,    8'hFF,  5'd0,  7'd0,   1'b1, 11'd9,  16'h0000);
        add_row(CMD_PUT,    CH_SPACE, 5'd0, 7'd0,  1'b1, 11'd10, 16'h0000);
        add_row(CMD_PUT,    8'h00,  5'd0,  7'd0,   1'b1, 11'd10, 16'h0000);
        add_row(CMD_PUT,    8'h1F,  5'd0,  7'd0,   1'b1, 11'd10, 16'h0000);
        add_row(CMD_PUT,    CH_CR,  5'd0,  7'd0,   1'b1, 11'd0,  16'h0000);
        add_row(CMD_PUT,    CH_LF,  5'd0,  7'd0,   1'b1, 11'd80, 16'h0000);
        add_row(CMD_PUT,    CH_BS,  5'd0,  7'd0,   1'b1, 11'd80, 16'h0000);
        add_row(CMD_READ,   8'h00,  5'd0,  7'd0,   1'b1, 11'd80, 16'h0F41);
        add_row(CMD_READ,   8'h00,  5'd0,  7'd8,   1'b1, 11'd80, 16'h0FFF);
        add_row(CMD_PUT,    CH_TAB, 5'd0,  7'd0,   1'b0, 11'd0,  16'h0000);
        add_row(CMD_CLEAR,  8'h00,  5'd0,  7'd0,   1'b1, 11'd0,  16'h0000);
        add_row(CMD_READ,   8'h00,  5'd0,  7'd0,   1'b1, 11'd0,  16'h0F20);
        add_row(CMD_PUT,    8'h7E,  5'd0,  7'd0,   1'b0, 11'd0,  16'h0000);
        add_row(CMD_READ,   8'h00,  5'd0,  7'd0,   1'b0, 11'd0,  16'h0000);
        for (int k = 0; k < stim_rows.size(); k++) begin
            send_item(stim_rows[k].req, stim_rows[k].typed, stim_rows[k].want);
        end
        drain_outcomes();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       begin fg_set = 4'h0; bg_set = 4'h0; end
                1:       begin fg_set = 4'hF; bg_set = 4'hF; end
                3:       begin fg_set = 4'h0; bg_set = 4'hF; end
                4:       begin fg_set = 4'hF; bg_set = 4'h0; end
                default: begin
                    fg_set = 4'($urandom_range(0, 15));
                    bg_set = 4'($urandom_range(0, 15));
                end
            endcase
            write_colour(REG_FG, fg_set);
            write_colour(REG_BG, bg_set);
            for (int n = 0; n < ITEMS_PHASE; n++) begin
                if (p == 1 && n == 100) hold_req = 1'b1;
                if (p == 2 && n == 50)  no_gaps = 1'b1;
                if (p == 2 && n == 250) no_gaps = 1'b0;
                // sender waits out every outstanding transaction once
                if (p == 3 && n == 150) drain_outcomes();
                send_item(random_console_req(), 1'b0, '0);
            end
            drain_outcomes();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_outcomes.size() != 0)
            flag_mismatch("results never seen", pending_outcomes.size(), 0);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tccw_pkg.sv
rtl/tccw_ram.sv
rtl/tccw_regs.sv
rtl/tccw_ctrl.sv
rtl/text_console_character_writer.sv
sim/tb.sv
